// ===== design/csl_pkg.sv =====
// Shared types, status codes and constants of the chunk-size line parser.
package csl_pkg;

  // Default digit limit of a chunk-size line
  localparam int CSL_MAX_DIGITS = 16;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 64;
  localparam int COUNT_W  = 32;
  localparam int NIBBLE_W = 4;

  // Status codes of a result beat
  localparam logic [STATUS_W-1:0] ST_MORE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UP_F   = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_LOW_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOW_F  = 8'h66;
  localparam logic [BYTE_W-1:0] HEX_TEN     = 8'd10;

  // Class of one incoming byte
  typedef struct packed {
    logic                is_hex;
    logic                is_cr;
    logic                is_lf;
    logic [NIBBLE_W-1:0] nibble;
  } byte_class_t;

endpackage

// ===== design/chunk_size_line_parser.sv =====
// A result beat appears in the cycle after its byte is accepted. Throughput:
// one byte per cycle unless the result channel stalls; the per-byte update
// of the line state is combinational, and the output register is refilled
// in the cycle it is drained. Synchronous active-high reset clears the line
// state, the length limit and the output register; no clearing pass is needed.
// Top level: chunk-size line parser, line state and output register.
module chunk_size_line_parser
  import csl_pkg::*;
#(
  parameter int MAX_DIGITS = CSL_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,
  // byte input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   data_byte,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SIZE_W-1:0]   chunk_size,
  output logic [COUNT_W-1:0]  consumed_length
);

  localparam int DigitW = $clog2(MAX_DIGITS + 1);
  localparam logic [DigitW-1:0] DigitLimit = DigitW'(MAX_DIGITS);

  // Line state
  logic [COUNT_W-1:0] length_limit;
  logic               expect_lf;
  logic               expect_lf_next;
  logic [DigitW-1:0]  digit_count;
  logic [DigitW-1:0]  digit_count_next;
  logic [SIZE_W-1:0]  size_accum;
  logic [SIZE_W-1:0]  size_accum_next;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;

  // Result of the current byte
  logic [STATUS_W-1:0] res_status;
  logic [SIZE_W-1:0]   res_size;
  logic [COUNT_W-1:0]  counted;
  logic                count_ok;
  logic                do_count;

  byte_class_t cls;
  logic        in_beat;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_beat   = in_valid && in_ready;

  csl_byte_decode u_decode (
    .data_byte (data_byte),
    .cls       (cls)
  );

  // Count may advance unless it would wrap or pass a nonzero limit
  assign count_ok = (byte_count != '1) &&
                    ((length_limit == '0) || (byte_count < length_limit));
  assign counted  = (do_count && count_ok) ? byte_count + COUNT_W'(1) : byte_count;

  // Work out the next line state and the result of this byte
  always_comb begin
    expect_lf_next   = expect_lf;
    digit_count_next = digit_count;
    size_accum_next  = size_accum;
    do_count         = 1'b0;
    res_status       = ST_MORE;
    if (expect_lf) begin
      if (cls.is_lf) begin
        do_count   = 1'b1;
        res_status = ST_DONE;
      end else begin
        res_status = ST_INVALID;
      end
    end else if (digit_count >= DigitLimit) begin
      res_status = ST_TOO_BIG;
    end else if (cls.is_cr) begin
      do_count       = 1'b1;
      expect_lf_next = 1'b1;
    end else if (cls.is_lf) begin
      do_count   = 1'b1;
      res_status = ST_DONE;
    end else if (cls.is_hex) begin
      do_count         = 1'b1;
      size_accum_next  = {size_accum[SIZE_W-NIBBLE_W-1:0], cls.nibble};
      digit_count_next = digit_count + DigitW'(1);
    end else begin
      res_status = ST_INVALID;
    end
    res_size = ((res_status == ST_MORE) || (res_status == ST_DONE)) ?
               size_accum_next : '0;
    byte_count_next = counted;
    // clear the line after done or error
    if (res_status != ST_MORE) begin
      expect_lf_next   = 1'b0;
      digit_count_next = '0;
      size_accum_next  = '0;
      byte_count_next  = '0;
    end
  end

  // Hold the length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      length_limit <= cfg_data;
    end
  end

  // Advance the line state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_lf   <= 1'b0;
      digit_count <= '0;
      size_accum  <= '0;
      byte_count  <= '0;
    end else if (in_beat) begin
      expect_lf   <= expect_lf_next;
      digit_count <= digit_count_next;
      size_accum  <= size_accum_next;
      byte_count  <= byte_count_next;
    end
  end

  // Output register: load on an input beat, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      status          <= res_status;
      chunk_size      <= res_size;
      consumed_length <= counted;
    end
  end

endmodule

// ===== design/csl_byte_decode.sv =====
// Byte classifier: marks CR, LF and hex digits and gives the digit value.
module csl_byte_decode
  import csl_pkg::*;
(
  input  logic [BYTE_W-1:0] data_byte,
  output byte_class_t       cls
);

  logic             is_dec;
  logic             is_up;
  logic             is_low;
  logic [BYTE_W-1:0] value;

  // Match the three digit ranges
  assign is_dec = (data_byte >= CHAR_ZERO)  && (data_byte <= CHAR_NINE);
  assign is_up  = (data_byte >= CHAR_UP_A)  && (data_byte <= CHAR_UP_F);
  assign is_low = (data_byte >= CHAR_LOW_A) && (data_byte <= CHAR_LOW_F);

  // Convert the digit to its value
  always_comb begin
    if (is_dec) begin
      value = data_byte - CHAR_ZERO;
    end else if (is_up) begin
      value = data_byte - CHAR_UP_A + HEX_TEN;
    end else begin
      value = data_byte - CHAR_LOW_A + HEX_TEN;
    end
  end

  assign cls.is_hex = is_dec || is_up || is_low;
  assign cls.is_cr  = (data_byte == CHAR_CR);
  assign cls.is_lf  = (data_byte == CHAR_LF);
  assign cls.nibble = value[NIBBLE_W-1:0];

endmodule

// ===== design/csl_checker.sv =====
// Port-level checker of the chunk-size line parser, bound to the top level.
module csl_checker
  import csl_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [SIZE_W-1:0]   chunk_size,
  input logic [COUNT_W-1:0]  consumed_length
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(chunk_size) && $stable(consumed_length))
    else $error("stalled result beat changed");

  // Error beats carry no size
  a_err_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_TOO_BIG || status == ST_INVALID) |-> chunk_size == '0)
    else $error("error beat with nonzero size");

  // Within a line the count never falls
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && status == ST_MORE) ##1 out_valid |->
    consumed_length >= $past(consumed_length))
    else $error("byte count fell within a line");

  // After a line ends the count restarts
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && status != ST_MORE) ##1 out_valid |->
    consumed_length <= COUNT_W'(1))
    else $error("byte count not restarted after line end");

endmodule

bind chunk_size_line_parser csl_checker u_csl_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .chunk_size      (chunk_size),
  .consumed_length (consumed_length)
);

// ===== tb/chunk_size_line_parser_checker.sv =====
`timescale 1ns / 1ps
// Checker for the chunk-size line parser: predicts each result beat and compares it.
module chunk_size_line_parser_checker
  import csl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] status,
  input  logic [SIZE_W-1:0]   chunk_size,
  input  logic [COUNT_W-1:0]  consumed_length,
  output int                  mismatches,
  output int                  pending,
  output int                  beats_checked
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   size;
    logic [COUNT_W-1:0]  consumed;
  } line_result_t;

  // Shadow copy of the limit register and the line state
  logic [COUNT_W-1:0] length_limit;
  logic               lf_wait;
  logic [4:0]         digit_total;
  logic [SIZE_W-1:0]  size_accum;
  logic [COUNT_W-1:0] byte_tally;

  line_result_t expected_results[$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    beats_checked = 0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Count one byte; hold at a nonzero limit or where the count would wrap
  task automatic tally_byte();
    logic [COUNT_W-1:0] next_tally;
    next_tally = byte_tally + COUNT_W'(1);
    if (next_tally != '0 && (length_limit == '0 || next_tally <= length_limit))
      byte_tally = next_tally;
  endtask

  task automatic clear_line();
    lf_wait     = 1'b0;
    digit_total = '0;
    size_accum  = '0;
    byte_tally  = '0;
  endtask

  // Advance the line state by one byte and work out the result beat it gives
  task automatic predict_line_byte(input logic [BYTE_W-1:0] b, output line_result_t res);
    logic                is_hex;
    logic [NIBBLE_W-1:0] nibble;
    logic [STATUS_W-1:0] st;
    is_hex = 1'b1;
    nibble = '0;
    st     = ST_MORE;
    if (b >= CHAR_ZERO && b <= CHAR_NINE)
      nibble = NIBBLE_W'(b - CHAR_ZERO);
    else if (b >= CHAR_UP_A && b <= CHAR_UP_F)
      nibble = NIBBLE_W'(b - CHAR_UP_A + HEX_TEN);
    else if (b >= CHAR_LOW_A && b <= CHAR_LOW_F)
      nibble = NIBBLE_W'(b - CHAR_LOW_A + HEX_TEN);
    else
      is_hex = 1'b0;

    if (lf_wait) begin
      if (b == CHAR_LF) begin
        tally_byte();
        st = ST_DONE;
      end else begin
        st = ST_INVALID;
      end
    end else if (digit_total >= CSL_MAX_DIGITS) begin
      st = ST_TOO_BIG;
    end else if (b == CHAR_CR) begin
      tally_byte();
      lf_wait = 1'b1;
    end else if (b == CHAR_LF) begin
      tally_byte();
      st = ST_DONE;
    end else if (!is_hex) begin
      st = ST_INVALID;
    end else begin
      size_accum  = {size_accum[SIZE_W-NIBBLE_W-1:0], nibble};
      digit_total = digit_total + 5'd1;
      tally_byte();
    end

    res.status   = st;
    res.size     = (st == ST_MORE || st == ST_DONE) ? size_accum : '0;
    res.consumed = byte_tally;
    if (st != ST_MORE)
      clear_line();
  endtask

  always @(posedge clk) begin
    line_result_t want;
    line_result_t seen;
    if (rst) begin
      length_limit = '0;
      clear_line();
      expected_results.delete();
    end else begin
      // Compare a result beat with the oldest expectation
      if (out_valid && out_ready) begin
        seen = '{status, chunk_size, consumed_length};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: status %0d size %0h",
                                    seen.status, seen.size));
        end else begin
          want = expected_results.pop_front();
          beats_checked++;
          if (seen.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", seen.status, want.status));
          if (seen.size !== want.size)
            report_mismatch($sformatf("chunk_size %0h, expected %0h", seen.size, want.size));
          if (seen.consumed !== want.consumed)
            report_mismatch($sformatf("consumed_length %0d, expected %0d",
                                      seen.consumed, want.consumed));
        end
      end
      // Predict from an accepted byte with the limit in force before this edge
      if (in_valid && in_ready) begin
        predict_line_byte(data_byte, want);
        expected_results = {expected_results, want};
      end
      if (cfg_valid && cfg_ready)
        length_limit = cfg_data;
    end
    pending <= expected_results.size();
  end

endmodule

// ===== tb/chunk_size_line_parser_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the chunk-size line parser: stimulus, idling and verdict.
module chunk_size_line_parser_tb;
  import csl_pkg::*;

  localparam int PHASES          = 6;
  localparam int BYTES_PER_PHASE = 155;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SIZE_W-1:0]   chunk_size;
  logic [COUNT_W-1:0]  consumed_length;

  int mismatches;
  int pending;
  int beats_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;
  int lines_sent    = 0;

  // Limit setting and idling of each phase
  logic [COUNT_W-1:0] phase_limit [PHASES] = '{32'd0, 32'd1, 32'd5, 32'hFFFF_FFFF, 32'd3, 32'd0};
  int phase_send_idle [PHASES] = '{19, 19, 66, 66, 0, 0};
  int phase_recv_idle [PHASES] = '{66, 66, 19, 19, 0, 0};

  initial begin
    forever #5 clk = ~clk;
  end

  chunk_size_line_parser DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .chunk_size      (chunk_size),
    .consumed_length (consumed_length)
  );

  chunk_size_line_parser_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .chunk_size      (chunk_size),
    .consumed_length (consumed_length),
    .mismatches      (mismatches),
    .pending         (pending),
    .beats_checked   (beats_checked)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  function automatic logic [BYTE_W-1:0] random_hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10)
      return CHAR_ZERO + BYTE_W'(v);
    else if (v < 16)
      return CHAR_UP_A + BYTE_W'(v - 10);
    else
      return CHAR_LOW_A + BYTE_W'(v - 16);
  endfunction

  // Mostly well-formed lines, some broken after CR, some pure noise
  task automatic send_random_line();
    int kind;
    int digits;
    kind = $urandom_range(0, 99);
    lines_sent++;
    if (kind < 80) begin
      digits = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 15);
      repeat (digits) send_byte(random_hex_char());
      if ($urandom_range(0, 2) == 0) begin
        send_byte(CHAR_LF);
      end else begin
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(0, 3)) send_byte(random_hex_char());
      send_byte(CHAR_CR);
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Hold off the sender until every expected beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = phase_send_idle[p];
      recv_idle_pct = phase_recv_idle[p];
      drain();
      write_limit(phase_limit[p]);

      if (p == 0) begin
        // empty line, lower-case digit with CR LF
        send_byte(CHAR_LF);
        send_text("a");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // bad characters, top of the byte range and zero
        send_text("G");
        send_byte(8'hFF);
        send_byte(8'h00);
        // CR followed by something other than LF
        send_text("1");
        send_byte(CHAR_CR);
        send_text("0");
        // sixteen digits fill the limit, the CR after them overflows
        send_text("0123456789abcdEF");
        send_byte(CHAR_CR);
        send_text("7");
        send_byte(CHAR_LF);
      end

      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) send_random_line();
    end

    drain();
    $display("Covered %0d bytes in %0d random lines under %0d length limits (0 and all ones too)",
             bytes_sent, lines_sent, PHASES);
    $display("Checked %0d result beats with %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("Timed out with %0d beats outstanding", pending);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== chunk_size_line_parser.f =====
design/csl_pkg.sv
design/csl_byte_decode.sv
design/chunk_size_line_parser.sv
design/csl_checker.sv
tb/chunk_size_line_parser_checker.sv
tb/chunk_size_line_parser_tb.sv
